/* design/seven_band_biquad_equalizer_defines.svh */
// ----------------------------------------------------------------------------
// Seven-band equalizer assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef SEVEN_BAND_BIQUAD_EQUALIZER_DEFINES_SVH
`define SEVEN_BAND_BIQUAD_EQUALIZER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst
`define SBBEQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst
`define SBBEQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/sbbeq_pkg.sv */
// ----------------------------------------------------------------------------
// Seven-band equalizer package
// Widths, shared types and the fixed coefficient tables of the band filters.
// ----------------------------------------------------------------------------
package sbbeq_pkg;

  localparam int NumBands = 7;
  localparam int BandW    = 3;
  localparam int WordW    = 32;
  localparam int ProdW    = 64;
  localparam int LevelW   = 4;
  localparam int MeterW   = 3;
  localparam int SampleW  = 12;
  localparam int EnergyW  = 63;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 4;
  localparam int FracBits = 10;

  typedef logic [BandW-1:0]        band_idx_t;
  typedef logic signed [WordW-1:0] word_t;
  typedef logic signed [ProdW-1:0] prod_t;

  localparam band_idx_t LastBand = band_idx_t'(NumBands - 1);

  // Register index of the meter select; lower indexes are band levels
  localparam logic [CfgIdxW-1:0] CfgMeterBand = CfgIdxW'(NumBands);

  // Write request into the delay store
  typedef struct packed {
    logic      we;
    band_idx_t band;
    word_t     d1;
    word_t     d2;
  } delay_wr_t;

  // First feedback coefficient per band
  function automatic word_t fb_one_coef(input band_idx_t b);
    word_t c;
    unique case (b)
      3'd0:    c = -32'sd2029;
      3'd1:    c = -32'sd2011;
      3'd2:    c = -32'sd1970;
      3'd3:    c = -32'sd1878;
      3'd4:    c = -32'sd1660;
      3'd5:    c = -32'sd1115;
      3'd6:    c = 32'sd141;
      default: c = '0;
    endcase
    return c;
  endfunction

  // Second feedback coefficient per band
  function automatic word_t fb_two_coef(input band_idx_t b);
    word_t c;
    unique case (b)
      3'd0:    c = 32'sd1006;
      3'd1:    c = 32'sd988;
      3'd2:    c = 32'sd955;
      3'd3:    c = 32'sd890;
      3'd4:    c = 32'sd772;
      3'd5:    c = 32'sd569;
      3'd6:    c = 32'sd239;
      default: c = '0;
    endcase
    return c;
  endfunction

  // Fixed band gain
  function automatic word_t band_gain_coef(input band_idx_t b);
    word_t c;
    unique case (b)
      3'd0:    c = 32'sd8;
      3'd1:    c = 32'sd17;
      3'd2:    c = 32'sd34;
      3'd3:    c = 32'sd66;
      3'd4:    c = 32'sd125;
      3'd5:    c = 32'sd227;
      3'd6:    c = 32'sd392;
      default: c = '0;
    endcase
    return c;
  endfunction

  // Attenuation step gain, step 0 is unity in Q10
  function automatic word_t level_gain_coef(input logic [LevelW-1:0] l);
    word_t c;
    unique case (l)
      4'd0:  c = 32'sd1024;
      4'd1:  c = 32'sd790;
      4'd2:  c = 32'sd610;
      4'd3:  c = 32'sd471;
      4'd4:  c = 32'sd364;
      4'd5:  c = 32'sd281;
      4'd6:  c = 32'sd217;
      4'd7:  c = 32'sd167;
      4'd8:  c = 32'sd129;
      4'd9:  c = 32'sd99;
      4'd10: c = 32'sd77;
      4'd11: c = 32'sd59;
      4'd12: c = 32'sd46;
      4'd13: c = 32'sd35;
      4'd14: c = 32'sd27;
      4'd15: c = 32'sd21;
    endcase
    return c;
  endfunction

endpackage

/* design/sbbeq_mult.sv */
// ----------------------------------------------------------------------------
// Shared multiplier
// One signed 32x32 multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
module sbbeq_mult (
  input  logic           clk,
  input  logic           en,
  input  sbbeq_pkg::word_t a,
  input  sbbeq_pkg::word_t b,
  output sbbeq_pkg::prod_t prod
);
  import sbbeq_pkg::*;

  // Capture the product; hold it when idle
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= prod_t'(a) * prod_t'(b);
    end
  end

endmodule

/* design/sbbeq_delay.sv */
// ----------------------------------------------------------------------------
// Band delay store
// Both delay taps of the seven band sections, one band read and written.
// ----------------------------------------------------------------------------
module sbbeq_delay (
  input  logic                  clk,
  input  logic                  rst,
  input  sbbeq_pkg::band_idx_t  band,
  input  sbbeq_pkg::delay_wr_t  wr,
  output sbbeq_pkg::word_t      h1,
  output sbbeq_pkg::word_t      h2
);
  import sbbeq_pkg::*;

  word_t delay_one [NumBands];
  word_t delay_two [NumBands];

  // Clear on reset, update one band per write
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumBands; i++) begin
        delay_one[i] <= '0;
        delay_two[i] <= '0;
      end
    end else if (wr.we) begin
      delay_one[wr.band] <= wr.d1;
      delay_two[wr.band] <= wr.d2;
    end
  end

  // Read the band in work
  assign h1 = delay_one[band];
  assign h2 = delay_two[band];

endmodule

/* design/seven_band_biquad_equalizer.sv */
// ----------------------------------------------------------------------------
// Seven-band biquad equalizer
// Runs each sample through seven Q10 bandpass sections on one shared
// multiplier, scales, sums and halves the bands, and squares the metered band.
// ----------------------------------------------------------------------------
//
//   channel   signals                                    direction
//   sample    sample_valid, sample_ready, sample         in
//   result    result_valid, result_ready,                out
//             equalized, energy_term
//   config    cfg_we, cfg_index, cfg_data                in
//
// From acceptance, each of the seven bands passes the first and second
// feedback, update, gain, level and accumulate steps on the one multiplier;
// then the metered band is squared and the result loaded. The next sample is
// taken in the cycle after the load. The sample port is ready only in idle; a
// result waiting in the output register stalls only the load of the next one.
// Reset clears the band delays, the levels, the meter select and result_valid.
//
module seven_band_biquad_equalizer (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               sample_valid,
  output logic                               sample_ready,
  input  logic [sbbeq_pkg::SampleW-1:0]      sample,
  output logic                               result_valid,
  input  logic                               result_ready,
  output logic signed [sbbeq_pkg::WordW-1:0] equalized,
  output logic [sbbeq_pkg::EnergyW-1:0]      energy_term,
  input  logic                               cfg_we,
  input  logic [sbbeq_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [sbbeq_pkg::CfgDataW-1:0]     cfg_data
);
  import sbbeq_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_FB1   = 9'b000000010,
    S_FB2   = 9'b000000100,
    S_UPD   = 9'b000001000,
    S_GAIN  = 9'b000010000,
    S_LEVEL = 9'b000100000,
    S_ACC   = 9'b001000000,
    S_SQR   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t               state, state_next;
  band_idx_t            band;
  logic [SampleW-1:0]   x_reg;
  word_t                t_reg;
  word_t                tmp_reg;
  word_t                sum_reg;
  word_t                meter_scaled;
  logic [LevelW-1:0]    levels [NumBands];
  logic [MeterW-1:0]    meter;

  logic                 mul_en;
  word_t                mul_a, mul_b;
  prod_t                prod;
  word_t                prod_lo, prod_asr;
  word_t                h1, h2;
  word_t                x_q10, s_full, s_two;
  delay_wr_t            delay_wr;
  logic                 load_out;

  sbbeq_mult u_mult (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  sbbeq_delay u_delay (
    .clk  (clk),
    .rst  (rst),
    .band (band),
    .wr   (delay_wr),
    .h1   (h1),
    .h2   (h2)
  );

  // Datapath around the product
  assign prod_lo  = prod[WordW-1:0];
  assign prod_asr = prod_lo >>> FracBits;
  assign x_q10    = word_t'({x_reg, {FracBits{1'b0}}});
  assign s_full   = t_reg - prod_lo;
  assign s_two    = s_full - (h2 <<< FracBits);

  // New delay taps of the band in work
  assign delay_wr.we   = (state == S_UPD);
  assign delay_wr.band = band;
  assign delay_wr.d1   = s_full >>> FracBits;
  assign delay_wr.d2   = h1;

  assign sample_ready = (state == S_IDLE);
  assign load_out     = (state == S_DONE) && (!result_valid || result_ready);

  // Sequence the shared multiplier
  always_comb begin
    state_next = state;
    mul_en     = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state)
      S_IDLE: begin
        if (sample_valid) state_next = S_FB1;
      end
      S_FB1: begin
        mul_en     = 1'b1;
        mul_a      = fb_one_coef(band);
        mul_b      = h1;
        state_next = S_FB2;
      end
      S_FB2: begin
        mul_en     = 1'b1;
        mul_a      = fb_two_coef(band);
        mul_b      = h2;
        state_next = S_UPD;
      end
      S_UPD: begin
        state_next = S_GAIN;
      end
      S_GAIN: begin
        mul_en     = 1'b1;
        mul_a      = band_gain_coef(band);
        mul_b      = tmp_reg;
        state_next = S_LEVEL;
      end
      S_LEVEL: begin
        mul_en     = 1'b1;
        mul_a      = level_gain_coef(levels[band]);
        mul_b      = prod_asr;
        state_next = S_ACC;
      end
      S_ACC: begin
        state_next = (band == LastBand) ? S_SQR : S_FB1;
      end
      S_SQR: begin
        mul_en     = 1'b1;
        mul_a      = meter_scaled;
        mul_b      = meter_scaled;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (load_out) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Advance the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the working values of the item
  always_ff @(posedge clk) begin
    if (rst) begin
      band <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (sample_valid) begin
            x_reg        <= sample;
            band         <= '0;
            sum_reg      <= '0;
            meter_scaled <= '0;
          end
        end
        S_FB2: t_reg   <= x_q10 - prod_lo;
        S_UPD: tmp_reg <= s_two >>> FracBits;
        S_ACC: begin
          sum_reg <= sum_reg + prod_asr;
          if (band == meter) meter_scaled <= prod_asr;
          if (band != LastBand) band <= band + 3'd1;
        end
        default: ;
      endcase
    end
  end

  // Output register, drop valid when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      equalized   <= sum_reg >>> 1;
      energy_term <= prod[EnergyW-1:0];
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      meter <= '0;
      for (int i = 0; i < NumBands; i++) levels[i] <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CfgMeterBand) begin
        meter <= cfg_data[MeterW-1:0];
      end else begin
        levels[cfg_index] <= cfg_data;
      end
    end
  end

endmodule

/* design/sbbeq_checker.sv */
// ----------------------------------------------------------------------------
// Seven-band equalizer port checker
// Watches the top level's ports over time, attached by bind.
// ----------------------------------------------------------------------------
`include "seven_band_biquad_equalizer_defines.svh"

module sbbeq_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               sample_valid,
  input logic                               sample_ready,
  input logic                               result_valid,
  input logic                               result_ready,
  input logic signed [sbbeq_pkg::WordW-1:0] equalized,
  input logic [sbbeq_pkg::EnergyW-1:0]      energy_term
);
  import sbbeq_pkg::*;

  // A stalled result holds
  `SBBEQ_ASSERT_NEXT(a_result_hold, result_valid && !result_ready,
    result_valid && $stable(equalized) && $stable(energy_term),
    "result changed while stalled")

  // An accepted item keeps the port busy
  `SBBEQ_ASSERT_NEXT(a_busy_after_accept, sample_valid && sample_ready,
    !sample_ready, "sample port ready right after accept")

  // A fresh result appears only as the sequencer goes idle
  `SBBEQ_ASSERT_NOW(a_result_at_idle, $rose(result_valid), sample_ready,
    "result loaded while busy")

  // A square never exceeds two to the 62
  `SBBEQ_ASSERT_NOW(a_energy_range, result_valid && energy_term[EnergyW-1],
    energy_term[EnergyW-2:0] == '0, "energy term out of range")

endmodule

bind seven_band_biquad_equalizer sbbeq_checker u_checker (.*);
